@@ src/med3x3_pkg.sv @@
// ----------------------------------------------------------------------------
// med3x3_pkg: shared types, constants and compare helpers
// Pixel layout, configuration codes and the small sorting functions used by
// the window lanes and the output merge of the 3x3 RGB median filter.
// ----------------------------------------------------------------------------
package med3x3_pkg;

  // Geometry limits
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_HEIGHT    = 4096;

  // Channel and counter widths
  localparam int CH_W     = 8;
  localparam int NCH      = 3;
  localparam int PIX_W    = NCH * CH_W;
  localparam int LW_REG_W = 12;
  localparam int FH_REG_W = 13;
  localparam int ROW_W    = 12;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic [LW_REG_W-1:0] LINE_WIDTH_RST   = 12'd640;
  localparam logic [FH_REG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  typedef logic [CH_W-1:0] chan_t;

  // Blue sits in the low byte
  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pix_t;

  // Column-major window: [0..2] oldest column, [6..8] newest column
  typedef pix_t [8:0] win_t;

  // Sorted triple
  typedef struct packed {
    chan_t hi;
    chan_t md;
    chan_t lo;
  } trio_t;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic valid;
    logic last;
  } stg_ctl_t;

  function automatic chan_t min2(input chan_t a, input chan_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic chan_t max2(input chan_t a, input chan_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic chan_t min3(input chan_t a, input chan_t b, input chan_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic chan_t max3(input chan_t a, input chan_t b, input chan_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic chan_t med3(input chan_t a, input chan_t b, input chan_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // Three compare-exchange steps
  function automatic trio_t sort3(input chan_t a, input chan_t b, input chan_t c);
    chan_t lo1;
    chan_t hi1;
    chan_t t;
    trio_t r;
    lo1  = min2(a, b);
    hi1  = max2(a, b);
    r.lo = min2(lo1, c);
    t    = max2(lo1, c);
    r.md = min2(hi1, t);
    r.hi = max2(hi1, t);
    return r;
  endfunction

endpackage

@@ src/med3x3_line_buf.sv @@
// ----------------------------------------------------------------------------
// med3x3_line_buf: line memory, position counters and 3x3 window
// Holds the two previous rows in one dual-row memory, tracks row and column,
// and presents a registered 3x3 pixel window for every interior pixel.
// ----------------------------------------------------------------------------
module med3x3_line_buf
  import med3x3_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_wr_t  cfg_wr,
  input  logic     in_valid,
  output logic     in_ready,
  input  pix_t     in_pix,
  input  logic     dn_ready,
  output stg_ctl_t win_ctl,
  output win_t     win
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > LW_REG_W) ? CW + 1 : LW_REG_W;
  localparam logic [WW-1:0]       W_MIN = WW'(3);
  localparam logic [WW-1:0]       W_MAX = WW'(MAX_WIDTH);
  localparam logic [FH_REG_W-1:0] H_MIN = FH_REG_W'(3);
  localparam logic [FH_REG_W-1:0] H_MAX = FH_REG_W'(MAX_HEIGHT);

  logic [LW_REG_W-1:0] line_width_r;
  logic [FH_REG_W-1:0] frame_height_r;
  logic [WW-1:0]       lw_ext;
  logic [WW-1:0]       w_eff;
  logic [FH_REG_W-1:0] h_eff;

  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [WW-1:0]    col_inc;
  logic [FH_REG_W-1:0] row_inc;
  logic             last_col, last_row, emit, acc;

  // line memory: upper row in the high half, middle row in the low half
  logic [2*PIX_W-1:0] mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_r;
  pix_t               top_px, mid_px;

  // stage 1
  logic          s1_v_r, s1_emit_r, s1_last_r;
  pix_t          s1_pix_r;
  logic [CW-1:0] s1_addr_r;
  logic          s1_go, rdy2;

  // window columns: [0..2] two back, [3..5] one back
  pix_t wc_r [6];
  win_t nb;

  // stage 2
  logic s2_v_r, s2_last_r;
  win_t s2_win_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= LINE_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        CFG_LINE_WIDTH:   line_width_r   <= cfg_wr.data[LW_REG_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wr.data[FH_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp geometry to the supported range
  always_comb begin
    lw_ext = WW'(line_width_r);
    if (lw_ext < W_MIN)      w_eff = W_MIN;
    else if (lw_ext > W_MAX) w_eff = W_MAX;
    else                     w_eff = lw_ext;
    if (frame_height_r < H_MIN)      h_eff = H_MIN;
    else if (frame_height_r > H_MAX) h_eff = H_MAX;
    else                             h_eff = frame_height_r;
  end

  // Position bookkeeping
  assign acc      = in_valid && in_ready;
  assign col_inc  = WW'(col_r) + WW'(1);
  assign row_inc  = FH_REG_W'(row_r) + FH_REG_W'(1);
  assign last_col = (col_inc >= w_eff);
  assign last_row = (row_inc >= h_eff);
  assign emit     = (row_r >= ROW_W'(2)) && (col_r >= CW'(2));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Handshake through stages 1 and 2
  assign rdy2     = !s2_v_r || dn_ready;
  assign s1_go    = s1_v_r && rdy2;
  assign in_ready = !s1_v_r || rdy2;

  // Line memory: read on transfer, write back when the pixel leaves stage 1
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_r <= mem[col_r];
    end
    if (s1_go) begin
      mem[s1_addr_r] <= {mid_px, s1_pix_r};
    end
  end

  assign top_px = rd_r[2*PIX_W-1:PIX_W];
  assign mid_px = rd_r[PIX_W-1:0];

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r  <= in_pix;
      s1_addr_r <= col_r;
      s1_emit_r <= emit;
      s1_last_r <= last_col && last_row;
    end
  end

  // Window assembly
  always_comb begin
    nb[0] = wc_r[0];
    nb[1] = wc_r[1];
    nb[2] = wc_r[2];
    nb[3] = wc_r[3];
    nb[4] = wc_r[4];
    nb[5] = wc_r[5];
    nb[6] = top_px;
    nb[7] = mid_px;
    nb[8] = s1_pix_r;
  end

  // Window shift, one column per pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        wc_r[i] <= '0;
      end
    end else if (s1_go) begin
      wc_r[0] <= wc_r[3];
      wc_r[1] <= wc_r[4];
      wc_r[2] <= wc_r[5];
      wc_r[3] <= top_px;
      wc_r[4] <= mid_px;
      wc_r[5] <= s1_pix_r;
    end
  end

  // Stage 2: interior pixels only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (rdy2) begin
      s2_v_r <= s1_v_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_last_r <= s1_last_r;
      s2_win_r  <= nb;
    end
  end

  assign win_ctl.valid = s2_v_r;
  assign win_ctl.last  = s2_last_r;
  assign win           = s2_win_r;

  // A frame end always lands on an interior pixel
  a_last_is_interior: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s1_last_r |-> s1_emit_r)
    else $error("frame end marked on a border pixel");

  // Frame end wraps both counters
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    acc && last_col && last_row |=> (col_r == '0) && (row_r == '0))
    else $error("counters did not wrap at frame end");

endmodule

@@ src/med3x3_lane.sv @@
// ----------------------------------------------------------------------------
// med3x3_lane: per-channel window reduction
// Sorts the three window columns, then reduces them to the max of the lows,
// the median of the middles and the min of the highs. Two register stages.
// ----------------------------------------------------------------------------
module med3x3_lane
  import med3x3_pkg::*;
(
  input  logic        clk,
  input  logic        en_a,
  input  logic        en_b,
  input  chan_t [8:0] taps,   // column-major, three taps per column
  output trio_t       trio
);

  trio_t srt_r [3];
  trio_t trio_r;

  // Stage A: sort each column
  always_ff @(posedge clk) begin
    if (en_a) begin
      for (int c = 0; c < 3; c++) begin
        srt_r[c] <= sort3(taps[3*c], taps[3*c+1], taps[3*c+2]);
      end
    end
  end

  // Stage B: cross-column reduction
  always_ff @(posedge clk) begin
    if (en_b) begin
      trio_r.lo <= max3(srt_r[0].lo, srt_r[1].lo, srt_r[2].lo);
      trio_r.md <= med3(srt_r[0].md, srt_r[1].md, srt_r[2].md);
      trio_r.hi <= min3(srt_r[0].hi, srt_r[1].hi, srt_r[2].hi);
    end
  end

  assign trio = trio_r;

endmodule

@@ src/median3x3_rgb_filter.sv @@
// A pixel that completes a window passes the line read, window, column sort,
// reduce and merge registers in that order before its result is on out_tdata.
// Throughput: one pixel per cycle when out_tready does not stall, bounded by one
// read and one write of the line memory per pixel; border pixels give no result.
// Reset (rst_n low, synchronous) clears counters, window, pipeline valids
// and sets line_width to 640, frame_height to 480; line memory is not cleared.
// ----------------------------------------------------------------------------
// median3x3_rgb_filter: 3x3 median filter over an RGB pixel stream
// Line buffer and window feed three channel lanes; the merge stage takes the
// median of each lane's three candidates and drives the output register.
// ----------------------------------------------------------------------------
module median3x3_rgb_filter
  import med3x3_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,   // blue, green, red
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [PIX_W-1:0]      out_tdata,  // median_blue, median_green, median_red
  output logic                  out_tlast,  // frame_last
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_wr_t  cfg_wr;
  stg_ctl_t win_ctl;
  win_t     win;
  logic     rdy3, rdy4, rdy5;

  logic v3_r, v4_r, l3_r, l4_r;
  logic out_v_r, out_last_r;
  pix_t out_pix_r;

  chan_t [8:0] lane_taps [NCH];
  trio_t       lane_trio [NCH];
  pix_t        merged;

  assign cfg_ready     = 1'b1;
  assign cfg_wr.valid  = cfg_valid;
  assign cfg_wr.index  = cfg_index;
  assign cfg_wr.data   = cfg_data;

  // Ready chain back from the output register
  assign rdy5 = !out_v_r || out_tready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;

  med3x3_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_wr),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_pix   (pix_t'(in_tdata)),
    .dn_ready (rdy3),
    .win_ctl  (win_ctl),
    .win      (win)
  );

  // One lane per color channel
  for (genvar ch = 0; ch < NCH; ch++) begin : g_lane
    for (genvar k = 0; k < 9; k++) begin : g_tap
      assign lane_taps[ch][k] = win[k][ch*CH_W +: CH_W];
    end

    med3x3_lane u_lane (
      .clk  (clk),
      .en_a (rdy3),
      .en_b (rdy4),
      .taps (lane_taps[ch]),
      .trio (lane_trio[ch])
    );

    assign merged[ch*CH_W +: CH_W] =
      med3(lane_trio[ch].lo, lane_trio[ch].md, lane_trio[ch].hi);
  end

  // Valid tracking alongside the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy3) v3_r    <= win_ctl.valid;
      if (rdy4) v4_r    <= v3_r;
      if (rdy5) out_v_r <= v4_r;
    end
  end

  // Frame-end flag and output payload
  always_ff @(posedge clk) begin
    if (rdy3) l3_r <= win_ctl.last;
    if (rdy4) l4_r <= l3_r;
    if (rdy5) begin
      out_last_r <= l4_r;
      out_pix_r  <= merged;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_last_r;

  // With the output register empty nothing upstream can stall
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_tready && rdy3)
    else $error("input stalled with empty output register");

  // A taken result with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_tready && !v4_r |=> !out_v_r)
    else $error("result repeated after transfer");

endmodule
